@@ rtl/q2e_pkg.sv @@
// ----------------------------------------------------------------------------
// q2e_pkg
// Types, constants and helper functions shared by the quaternion to Euler
// angle pipeline: vector and beat payload structs, status codes, the CORDIC
// arctangent table and the final rounding and clamping.
// ----------------------------------------------------------------------------
package q2e_pkg;

    // Datapath widths
    localparam int XW = 37;     // CORDIC x/y, holds |v| up to 2^33 with gain
    localparam int ZW = 25;     // angle accumulator, 1/32768 degree
    localparam int PW = 34;     // quadratic sums of the quaternion
    localparam int ISQ_STEPS = 32;
    localparam int ATAN_LEN = 24;

    // Angles in 1/32768 degree and output limits in 1/128 degree
    localparam logic signed [ZW-1:0] DEG90_FINE = 25'sd2949120;
    localparam logic [15:0] ROLL_LIMIT  = 16'd23040;
    localparam logic [15:0] PITCH_LIMIT = 16'd11520;

    // Status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_SAT  = 2'd1;
    localparam logic [1:0] ST_ZERO = 2'd2;

    // One vector in flight through the CORDIC
    typedef struct packed {
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic signed [ZW-1:0] z;
        logic                 zero;   // atan2 of (0,0): angle forced to 0
    } vec_t;

    // Beat through the square root cells
    typedef struct packed {
        logic [62:0]          rem;
        logic [63:0]          root;
        logic signed [XW-1:0] h;
        vec_t                 roll;
        vec_t                 yaw;
        logic [1:0]           status;
    } isq_t;

    // Beat through the CORDIC cells
    typedef struct packed {
        vec_t       roll;
        vec_t       pitch;
        vec_t       yaw;
        logic [1:0] status;
    } cord_t;

    // atan(2^-i) in 1/32768 degree, rounded to nearest
    function automatic logic signed [ZW-1:0] atan_fine(input int i);
        logic signed [ZW-1:0] a;
        case (i)
            0:  a = 25'sd1474560;
            1:  a = 25'sd870484;
            2:  a = 25'sd459940;
            3:  a = 25'sd233473;
            4:  a = 25'sd117189;
            5:  a = 25'sd58652;
            6:  a = 25'sd29333;
            7:  a = 25'sd14667;
            8:  a = 25'sd7334;
            9:  a = 25'sd3667;
            10: a = 25'sd1833;
            11: a = 25'sd917;
            12: a = 25'sd458;
            13: a = 25'sd229;
            14: a = 25'sd115;
            15: a = 25'sd57;
            16: a = 25'sd29;
            17: a = 25'sd14;
            18: a = 25'sd7;
            19: a = 25'sd4;
            20: a = 25'sd2;
            21: a = 25'sd1;
            default: a = '0;
        endcase
        return a;
    endfunction

    // Turn a vector with negative x by 90 degrees toward the right half plane
    function automatic vec_t pre_rotate(input logic signed [PW-1:0] y,
                                        input logic signed [PW-1:0] x,
                                        input logic                 zq);
        vec_t v;
        v.zero = zq || (x == '0 && y == '0);
        if (x[PW-1]) begin
            if (!y[PW-1]) begin
                v.x = XW'(y);
                v.y = -XW'(x);
                v.z = DEG90_FINE;
            end
            else begin
                v.x = -XW'(y);
                v.y = XW'(x);
                v.z = -DEG90_FINE;
            end
        end
        else begin
            v.x = XW'(x);
            v.y = XW'(y);
            v.z = '0;
        end
        return v;
    endfunction

    // Accumulator to 1/128 degree, half away from zero, clamped to +-limit
    function automatic logic signed [15:0] round_clamp(input logic signed [ZW-1:0] z,
                                                       input logic                 zero,
                                                       input logic [15:0]          limit);
        logic [ZW-1:0] az;
        logic [ZW-1:0] mag;
        logic [15:0]   cl;
        az  = z[ZW-1] ? ZW'(-z) : ZW'(z);
        mag = (az + ZW'(128)) >> 8;
        cl  = (mag > ZW'(limit)) ? limit : mag[15:0];
        if (zero)
            return '0;
        return z[ZW-1] ? -$signed(cl) : $signed(cl);
    endfunction

endpackage

@@ rtl/q2e_front.sv @@
// ----------------------------------------------------------------------------
// q2e_front
// Front end: the ten quaternion products, the quadratic sums, pitch argument
// saturation, pre-rotation of the roll and yaw vectors and the product whose
// square root gives the pitch cosine term. Four registered stages.
// ----------------------------------------------------------------------------
module q2e_front
    import q2e_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [15:0] quat_w,
    input  logic signed [15:0] quat_x,
    input  logic signed [15:0] quat_y,
    input  logic signed [15:0] quat_z,
    output logic               out_valid,
    input  logic               out_ready,
    output isq_t               out_data
);

    typedef struct packed {
        logic signed [31:0] sw, sx, sy, sz, yw, xz, yz, xw, xy, zw;
    } prod_t;

    typedef struct packed {
        logic signed [PW-1:0] m, h, rx, ry, yx, yy;
        logic [1:0]           status;
        logic                 zq;
    } sum_t;

    typedef struct packed {
        logic [31:0]          a;
        logic [32:0]          b;
        logic signed [XW-1:0] h;
        vec_t                 roll;
        vec_t                 yaw;
        logic [1:0]           status;
    } prep_t;

    logic [3:0] v_reg;
    logic [3:0] rdy;
    prod_t      s1_reg, s1_next;
    sum_t       s2_reg, s2_next;
    prep_t      s3_reg, s3_next;
    isq_t       s4_reg, s4_next;

    logic signed [PW-1:0] n, s;
    logic signed [PW-1:0] ah;
    logic signed [PW-1:0] a_full, b_full;
    logic [64:0]          prod;

    // Ready chain: a stage takes a beat when empty or when it moves on
    assign rdy[3]    = !v_reg[3] || out_ready;
    assign rdy[2]    = !v_reg[2] || rdy[3];
    assign rdy[1]    = !v_reg[1] || rdy[2];
    assign rdy[0]    = !v_reg[0] || rdy[1];
    assign in_ready  = rdy[0];
    assign out_valid = v_reg[3];
    assign out_data  = s4_reg;

    // Stage 1: products
    always_comb
    begin
        s1_next.sw = quat_w * quat_w;
        s1_next.sx = quat_x * quat_x;
        s1_next.sy = quat_y * quat_y;
        s1_next.sz = quat_z * quat_z;
        s1_next.yw = quat_y * quat_w;
        s1_next.xz = quat_x * quat_z;
        s1_next.yz = quat_y * quat_z;
        s1_next.xw = quat_x * quat_w;
        s1_next.xy = quat_x * quat_y;
        s1_next.zw = quat_z * quat_w;
    end

    // Stage 2: sums and pitch argument check
    always_comb
    begin
        n = PW'(s1_reg.sw) + PW'(s1_reg.sx) + PW'(s1_reg.sy) + PW'(s1_reg.sz);
        s = (PW'(s1_reg.yw) - PW'(s1_reg.xz)) <<< 1;
        s2_next.m  = n >>> 1;
        s2_next.rx = PW'(s1_reg.sw) - PW'(s1_reg.sx) - PW'(s1_reg.sy) + PW'(s1_reg.sz);
        s2_next.ry = (PW'(s1_reg.yz) + PW'(s1_reg.xw)) <<< 1;
        s2_next.yx = PW'(s1_reg.sw) + PW'(s1_reg.sx) - PW'(s1_reg.sy) - PW'(s1_reg.sz);
        s2_next.yy = (PW'(s1_reg.xy) + PW'(s1_reg.zw)) <<< 1;
        s2_next.zq = (n == '0);
        if (n == '0) begin
            s2_next.h      = s >>> 1;
            s2_next.status = ST_ZERO;
        end
        else if (s > n) begin
            s2_next.h      = n >>> 1;
            s2_next.status = ST_SAT;
        end
        else if (s < -n) begin
            s2_next.h      = -(n >>> 1);
            s2_next.status = ST_SAT;
        end
        else begin
            s2_next.h      = s >>> 1;
            s2_next.status = ST_OK;
        end
    end

    // Stage 3: (m - |h|), (m + |h|) and pre-rotation
    always_comb
    begin
        ah     = s2_reg.h[PW-1] ? -s2_reg.h : s2_reg.h;
        a_full = s2_reg.m - ah;
        b_full = s2_reg.m + ah;
        s3_next.a      = a_full[31:0];
        s3_next.b      = b_full[32:0];
        s3_next.h      = XW'(s2_reg.h);
        s3_next.roll   = pre_rotate(s2_reg.ry, s2_reg.rx, s2_reg.zq);
        s3_next.yaw    = pre_rotate(s2_reg.yy, s2_reg.yx, s2_reg.zq);
        s3_next.status = s2_reg.status;
    end

    // Stage 4: radicand for the pitch cosine term
    always_comb
    begin
        prod           = s3_reg.a * s3_reg.b;
        s4_next.rem    = prod[62:0];
        s4_next.root   = '0;
        s4_next.h      = s3_reg.h;
        s4_next.roll   = s3_reg.roll;
        s4_next.yaw    = s3_reg.yaw;
        s4_next.status = s3_reg.status;
    end

    // Stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            v_reg <= '0;
        end
        else begin
            if (rdy[0]) v_reg[0] <= in_valid;
            if (rdy[1]) v_reg[1] <= v_reg[0];
            if (rdy[2]) v_reg[2] <= v_reg[1];
            if (rdy[3]) v_reg[3] <= v_reg[2];
        end
    end

    // Stage payloads
    always_ff @(posedge clk)
    begin
        if (rdy[0] && in_valid) s1_reg <= s1_next;
        if (rdy[1] && v_reg[0]) s2_reg <= s2_next;
        if (rdy[2] && v_reg[1]) s3_reg <= s3_next;
        if (rdy[3] && v_reg[2]) s4_reg <= s4_next;
    end

endmodule

@@ rtl/q2e_isq_cell.sv @@
// ----------------------------------------------------------------------------
// q2e_isq_cell
// One cell of the square root chain: settles one result bit per cell with a
// trial subtract, and carries the rest of the beat along.
// ----------------------------------------------------------------------------
module q2e_isq_cell
    import q2e_pkg::*;
#(
    parameter int STEP = 0
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  isq_t in_data,
    output logic out_valid,
    input  logic out_ready,
    output isq_t out_data
);

    localparam logic [63:0] BIT = 64'(1) << (62 - 2 * STEP);

    logic        v_reg;
    isq_t        d_reg, d_next;
    logic [63:0] trial;

    assign in_ready  = !v_reg || out_ready;
    assign out_valid = v_reg;
    assign out_data  = d_reg;

    // Trial subtract for this bit
    always_comb
    begin
        d_next = in_data;
        trial  = in_data.root + BIT;
        if (64'(in_data.rem) >= trial) begin
            d_next.rem  = in_data.rem - trial[62:0];
            d_next.root = (in_data.root >> 1) + BIT;
        end
        else begin
            d_next.root = in_data.root >> 1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= 1'b0;
        else if (in_ready)
            v_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            d_reg <= d_next;
    end

endmodule

@@ rtl/q2e_cord_cell.sv @@
// ----------------------------------------------------------------------------
// q2e_cord_cell
// One vectoring CORDIC micro-rotation, applied to the roll, pitch and yaw
// vectors of a beat side by side.
// ----------------------------------------------------------------------------
module q2e_cord_cell
    import q2e_pkg::*;
#(
    parameter int STAGE = 0
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  cord_t in_data,
    output logic  out_valid,
    input  logic  out_ready,
    output cord_t out_data
);

    localparam logic signed [ZW-1:0] ANG = atan_fine(STAGE);

    logic  v_reg;
    cord_t d_reg, d_next;

    // Drive y toward zero, accumulate the angle
    function automatic vec_t rotate(input vec_t v);
        vec_t                 r;
        logic signed [XW-1:0] dx;
        logic signed [XW-1:0] dy;
        r  = v;
        dx = v.y >>> STAGE;
        dy = v.x >>> STAGE;
        if (!v.y[XW-1]) begin
            r.x = v.x + dx;
            r.y = v.y - dy;
            r.z = v.z + ANG;
        end
        else begin
            r.x = v.x - dx;
            r.y = v.y + dy;
            r.z = v.z - ANG;
        end
        return r;
    endfunction

    assign in_ready  = !v_reg || out_ready;
    assign out_valid = v_reg;
    assign out_data  = d_reg;

    always_comb
    begin
        d_next.roll   = rotate(in_data.roll);
        d_next.pitch  = rotate(in_data.pitch);
        d_next.yaw    = rotate(in_data.yaw);
        d_next.status = in_data.status;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= 1'b0;
        else if (in_ready)
            v_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            d_reg <= d_next;
    end

endmodule

@@ rtl/quaternion_to_euler_angles_unit.sv @@
// ----------------------------------------------------------------------------
// quaternion_to_euler_angles_unit
// Attitude quaternion (Q1.14) to ZYX Euler angles in 1/128 degree.
//
//  Channel | Handshake           | Payload
//  --------+---------------------+-------------------------------------------
//  input   | in_valid / in_stall | quat_w, quat_x, quat_y, quat_z
//  output  | out_valid/out_stall | roll_angle, pitch_angle, yaw_angle, status
//
// One beat per cycle is accepted while in_stall is low.
// Stages: 4 front, 32 square root, min(CORDIC_STAGES, 24) CORDIC, 1 output.
// Each cell holds one beat and hands it on as soon as the next one is free,
// so empty slots close up behind an output stall; in_stall rises only when
// every cell is full and the output beat is stalled.
// Reset clears the valid bits only; no state survives between beats.
// ----------------------------------------------------------------------------
module quaternion_to_euler_angles_unit
    import q2e_pkg::*;
#(
    parameter int CORDIC_STAGES = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [15:0] quat_w,
    input  logic signed [15:0] quat_x,
    input  logic signed [15:0] quat_y,
    input  logic signed [15:0] quat_z,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [15:0] roll_angle,
    output logic signed [14:0] pitch_angle,
    output logic signed [15:0] yaw_angle,
    output logic [1:0]         status
);

    localparam int NRUN = (CORDIC_STAGES > ATAN_LEN) ? ATAN_LEN : CORDIC_STAGES;

    logic  front_ready;
    isq_t  isq_d [0:ISQ_STEPS];
    logic  isq_v [0:ISQ_STEPS];
    logic  isq_r [0:ISQ_STEPS];
    cord_t cord_d [0:NRUN];
    logic  cord_v [0:NRUN];
    logic  cord_r [0:NRUN];

    logic               out_valid_reg;
    logic               out_rdy;
    logic signed [15:0] roll_reg, yaw_reg, pitch_full;
    logic signed [14:0] pitch_reg;
    logic [1:0]         status_reg;

    assign in_stall = !front_ready;

    // Products, sums and radicand
    q2e_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (front_ready),
        .quat_w    (quat_w),
        .quat_x    (quat_x),
        .quat_y    (quat_y),
        .quat_z    (quat_z),
        .out_valid (isq_v[0]),
        .out_ready (isq_r[0]),
        .out_data  (isq_d[0])
    );

    // Square root chain, one result bit per cell
    for (genvar k = 0; k < ISQ_STEPS; k++) begin : g_isq
        q2e_isq_cell #(.STEP(k)) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (isq_v[k]),
            .in_ready  (isq_r[k]),
            .in_data   (isq_d[k]),
            .out_valid (isq_v[k+1]),
            .out_ready (isq_r[k+1]),
            .out_data  (isq_d[k+1])
        );
    end

    // Pitch vector: (c, h) with c >= 0, no pre-rotation needed
    always_comb
    begin
        cord_d[0].roll        = isq_d[ISQ_STEPS].roll;
        cord_d[0].yaw         = isq_d[ISQ_STEPS].yaw;
        cord_d[0].status      = isq_d[ISQ_STEPS].status;
        cord_d[0].pitch.x     = XW'($signed({1'b0, isq_d[ISQ_STEPS].root[31:0]}));
        cord_d[0].pitch.y     = isq_d[ISQ_STEPS].h;
        cord_d[0].pitch.z     = '0;
        cord_d[0].pitch.zero  = (isq_d[ISQ_STEPS].h == '0) &&
                                (isq_d[ISQ_STEPS].root == '0);
    end
    assign cord_v[0]         = isq_v[ISQ_STEPS];
    assign isq_r[ISQ_STEPS]  = cord_r[0];

    // CORDIC chain
    for (genvar i = 0; i < NRUN; i++) begin : g_cord
        q2e_cord_cell #(.STAGE(i)) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (cord_v[i]),
            .in_ready  (cord_r[i]),
            .in_data   (cord_d[i]),
            .out_valid (cord_v[i+1]),
            .out_ready (cord_r[i+1]),
            .out_data  (cord_d[i+1])
        );
    end

    // Output register with rounding and clamping
    assign out_rdy      = !out_valid_reg || !out_stall;
    assign cord_r[NRUN] = out_rdy;
    assign pitch_full   = round_clamp(cord_d[NRUN].pitch.z, cord_d[NRUN].pitch.zero,
                                      PITCH_LIMIT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_rdy)
            out_valid_reg <= cord_v[NRUN];
    end

    always_ff @(posedge clk)
    begin
        if (out_rdy && cord_v[NRUN]) begin
            roll_reg   <= round_clamp(cord_d[NRUN].roll.z, cord_d[NRUN].roll.zero,
                                      ROLL_LIMIT);
            yaw_reg    <= round_clamp(cord_d[NRUN].yaw.z, cord_d[NRUN].yaw.zero,
                                      ROLL_LIMIT);
            pitch_reg  <= pitch_full[14:0];
            status_reg <= cord_d[NRUN].status;
        end
    end

    assign out_valid   = out_valid_reg;
    assign roll_angle  = roll_reg;
    assign pitch_angle = pitch_reg;
    assign yaw_angle   = yaw_reg;
    assign status      = status_reg;

    // Checks
    a_zero_angles: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == ST_ZERO) |->
            (roll_angle == '0 && pitch_angle == '0 && yaw_angle == '0))
        else $error("zero quaternion beat with nonzero angle");

    a_roll_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (roll_angle <= 16'sd23040 && roll_angle >= -16'sd23040 &&
                       yaw_angle <= 16'sd23040 && yaw_angle >= -16'sd23040))
        else $error("roll or yaw out of range");

    a_pitch_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (pitch_angle <= 15'sd11520 && pitch_angle >= -15'sd11520))
        else $error("pitch out of range");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status == ST_OK || status == ST_SAT || status == ST_ZERO))
        else $error("bad status code");

    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled while output side can move");

endmodule
